>>> rtl/core/lcs_pkg.sv
package lcs_pkg;

  localparam int unsigned LCS_WIDTH = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_GCD_STEP,
    ST_RED_K,
    ST_RED_S,
    ST_RED_N,
    ST_KMOD,
    ST_EU_CHECK,
    ST_EU_MUL,
    ST_EU_STEP,
    ST_FIN_MOD,
    ST_FIN_MUL,
    ST_DONE
  } lcs_state_t;

  typedef enum logic [3:0] {
    DIV_GCD1,
    DIV_GCD2,
    DIV_RK,
    DIV_RS,
    DIV_RN,
    DIV_KMOD,
    DIV_EUQ,
    DIV_SMOD
  } lcs_div_op_t;

  typedef struct packed {
    logic        load;
    logic        div_start;
    lcs_div_op_t div_op;
    logic        mul_start;
    logic        mul_fin;
    logic        eu_step;
    logic        gcd_swap;
    logic        gcd_next;
  } lcs_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic n_zero;
    logic gcd_b_zero;
    logic gcd_phase2;
    logic r1_zero;
    logic r0_one;
  } lcs_sts_t;

endpackage

>>> rtl/core/linear_congruence_solver_core.sv
// A solve runs the gcd remainder steps, the reductions by the gcd, the extended Euclid steps
// and the final modular multiply, one after another.
// Throughput: one item in flight, set by the shared bit-serial divider and multiplier; the
// next input transfer is taken the cycle after the result transfer.
// Reset (rst_n low, synchronous) returns the controller to idle; no data is cleared.
module linear_congruence_solver_core
  import lcs_pkg::*;
#(
  parameter int unsigned WIDTH = LCS_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_coeff,
  input  logic [31:0] in_target,
  input  logic [31:0] in_modulus,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_solution,
  output logic [31:0] out_reduced_modulus,
  output logic        out_solvable
);

  lcs_cmd_t         cmd;
  lcs_sts_t         sts;
  logic             res_ok;
  logic [WIDTH-1:0] sol, nred;
  logic [WIDTH-1:0] k_w, s_w, n_w;

  always_comb begin
    k_w = '0; s_w = '0; n_w = '0;
    for (int i = 0; i < WIDTH && i < 32; i++) begin
      k_w[i] = in_coeff[i];
      s_w[i] = in_target[i];
      n_w[i] = in_modulus[i];
    end
  end

  lcs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .res_ok, .cmd, .sts
  );

  lcs_dpath #(.WIDTH(WIDTH)) u_dpath (
    .clk, .in_coeff(k_w), .in_target(s_w), .in_modulus(n_w),
    .cmd, .sts, .sol, .nred
  );

  always_comb begin
    out_solution        = '0;
    out_reduced_modulus = '0;
    for (int i = 0; i < WIDTH && i < 32; i++) begin
      out_solution[i]        = res_ok ? sol[i] : 1'b0;
      out_reduced_modulus[i] = nred[i];
    end
    out_solvable = res_ok;
  end

endmodule

>>> rtl/core/lcs_ctrl.sv
module lcs_ctrl
  import lcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     res_ok,
  output lcs_cmd_t cmd,
  input  lcs_sts_t sts
);

  lcs_state_t state_r, state_nxt;
  logic       ok_r, ok_nxt;
  logic       busy_r, busy_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ok_r    <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ok_r    <= ok_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ok_nxt    = ok_r;
    busy_nxt  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_GCD_STEP;
          ok_nxt    = 1'b0;
        end
      end
      ST_GCD_STEP: begin
        if (sts.n_zero) begin
          state_nxt = ST_DONE;
        end else if (sts.gcd_b_zero) begin
          state_nxt = sts.gcd_phase2 ? ST_RED_K : ST_GCD_STEP;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        busy_nxt = 1'b1;
        if (busy_r && sts.div_done) state_nxt = ST_GCD_STEP;
      end
      ST_RED_K: begin
        busy_nxt = 1'b1;
        if (busy_r && sts.div_done) state_nxt = ST_RED_S;
      end
      ST_RED_S: begin
        busy_nxt = 1'b1;
        if (busy_r && sts.div_done) state_nxt = ST_RED_N;
      end
      ST_RED_N: begin
        busy_nxt = 1'b1;
        if (busy_r && sts.div_done) state_nxt = ST_KMOD;
      end
      ST_KMOD: begin
        busy_nxt = 1'b1;
        if (busy_r && sts.div_done) state_nxt = ST_EU_CHECK;
      end
      ST_EU_CHECK: begin
        if (sts.r1_zero) begin
          if (sts.r0_one) begin
            state_nxt = ST_FIN_MOD;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          state_nxt = ST_EU_STEP;
        end
      end
      ST_EU_STEP: begin
        busy_nxt = 1'b1;
        if (busy_r && sts.div_done) state_nxt = ST_EU_MUL;
      end
      ST_EU_MUL: begin
        busy_nxt = 1'b1;
        if (busy_r && sts.mul_done) state_nxt = ST_EU_CHECK;
      end
      ST_FIN_MOD: begin
        busy_nxt = 1'b1;
        if (busy_r && sts.div_done) state_nxt = ST_FIN_MUL;
      end
      ST_FIN_MUL: begin
        busy_nxt = 1'b1;
        if (busy_r && sts.mul_done) begin
          state_nxt = ST_DONE;
          ok_nxt    = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (state_nxt != state_r) busy_nxt = 1'b0;
  end

  always_comb begin
    cmd          = '0;
    cmd.div_op   = DIV_GCD1;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_GCD_STEP: begin
        if (!sts.n_zero && sts.gcd_b_zero && !sts.gcd_phase2) cmd.gcd_next = 1'b1;
      end
      ST_DIV: begin
        cmd.div_op    = sts.gcd_phase2 ? DIV_GCD2 : DIV_GCD1;
        cmd.div_start = !busy_r;
        cmd.gcd_swap  = busy_r && sts.div_done;
      end
      ST_RED_K: begin
        cmd.div_op    = DIV_RK;
        cmd.div_start = !busy_r;
      end
      ST_RED_S: begin
        cmd.div_op    = DIV_RS;
        cmd.div_start = !busy_r;
      end
      ST_RED_N: begin
        cmd.div_op    = DIV_RN;
        cmd.div_start = !busy_r;
      end
      ST_KMOD: begin
        cmd.div_op    = DIV_KMOD;
        cmd.div_start = !busy_r;
      end
      ST_EU_STEP: begin
        cmd.div_op    = DIV_EUQ;
        cmd.div_start = !busy_r;
      end
      ST_EU_MUL: begin
        cmd.mul_start = !busy_r;
        cmd.eu_step   = busy_r && sts.mul_done;
      end
      ST_FIN_MOD: begin
        cmd.div_op    = DIV_SMOD;
        cmd.div_start = !busy_r;
      end
      ST_FIN_MUL: begin
        cmd.mul_start = !busy_r;
        cmd.mul_fin   = 1'b1;
      end
      ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  assign res_ok = ok_r;

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> in_ready) else $error("load outside idle");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.div_start && cmd.mul_start)) else $error("two units started");
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule

>>> rtl/core/lcs_dpath.sv
module lcs_dpath
  import lcs_pkg::*;
#(
  parameter int unsigned WIDTH = LCS_WIDTH
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] in_coeff,
  input  logic [WIDTH-1:0] in_target,
  input  logic [WIDTH-1:0] in_modulus,
  input  lcs_cmd_t         cmd,
  output lcs_sts_t         sts,
  output logic [WIDTH-1:0] sol,
  output logic [WIDTH-1:0] nred
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] k_r, s_r, n_r, k_nxt, s_nxt, n_nxt;
  logic [WIDTH-1:0] ga_r, gb_r, ga_nxt, gb_nxt;
  logic             ph2_r, ph2_nxt;
  logic [WIDTH-1:0] r0_r, r1_r, t0_r, t1_r, r0_nxt, r1_nxt, t0_nxt, t1_nxt;
  logic [WIDTH-1:0] q_r, q_nxt, sm_r, sm_nxt, sol_r, sol_nxt;

  logic [WIDTH-1:0] dn_r, dd_r, dq_r, drem_r;
  logic [WIDTH-1:0] dn_nxt, dd_nxt, dq_nxt, drem_nxt;
  logic [CW-1:0]    dc_r, dc_nxt;
  logic             dbusy_r, dbusy_nxt;
  logic [WIDTH:0]   dtrial;

  logic [WIDTH-1:0] ma_r, mb_r, mm_r, macc_r;
  logic [WIDTH-1:0] ma_nxt, mb_nxt, mm_nxt, macc_nxt;
  logic [CW-1:0]    mc_r, mc_nxt;
  logic             mbusy_r, mbusy_nxt;
  logic [WIDTH:0]   mdbl, madd;
  logic [WIDTH-1:0] mdbl_m;
  logic [WIDTH-1:0] prod_sub;

  logic        div_wb_rk, div_wb_rs, div_wb_rn, div_wb_kmod, div_wb_euq;
  logic        mul_wb_fin;
  lcs_div_op_t op_r, op_nxt;
  logic        fin_r, fin_nxt;
  logic        dfin_r, mfin_r;

  always_ff @(posedge clk) begin
    k_r <= k_nxt; s_r <= s_nxt; n_r <= n_nxt;
    ga_r <= ga_nxt; gb_r <= gb_nxt; ph2_r <= ph2_nxt;
    r0_r <= r0_nxt; r1_r <= r1_nxt; t0_r <= t0_nxt; t1_r <= t1_nxt;
    q_r <= q_nxt; sm_r <= sm_nxt; sol_r <= sol_nxt;
    dn_r <= dn_nxt; dd_r <= dd_nxt; dq_r <= dq_nxt; drem_r <= drem_nxt;
    dc_r <= dc_nxt; dbusy_r <= dbusy_nxt;
    ma_r <= ma_nxt; mb_r <= mb_nxt; mm_r <= mm_nxt; macc_r <= macc_nxt;
    mc_r <= mc_nxt; mbusy_r <= mbusy_nxt;
  end

  // restoring divider, one quotient bit per cycle
  assign dtrial = {drem_r, dn_r[WIDTH-1]} - {1'b0, dd_r};

  always_comb begin
    dn_nxt = dn_r; dd_nxt = dd_r; dq_nxt = dq_r; drem_nxt = drem_r;
    dc_nxt = dc_r; dbusy_nxt = dbusy_r;
    if (cmd.div_start) begin
      dbusy_nxt = 1'b1;
      dc_nxt    = CW'(WIDTH);
      drem_nxt  = '0;
      dq_nxt    = '0;
      unique case (cmd.div_op)
        DIV_GCD1, DIV_GCD2: begin dn_nxt = ga_r; dd_nxt = gb_r; end
        DIV_RK:   begin dn_nxt = k_r; dd_nxt = ga_r; end
        DIV_RS:   begin dn_nxt = s_r; dd_nxt = ga_r; end
        DIV_RN:   begin dn_nxt = n_r; dd_nxt = ga_r; end
        DIV_KMOD: begin dn_nxt = k_r; dd_nxt = n_r; end
        DIV_EUQ:  begin dn_nxt = r0_r; dd_nxt = r1_r; end
        DIV_SMOD: begin dn_nxt = s_r; dd_nxt = n_r; end
        default:  begin dn_nxt = ga_r; dd_nxt = gb_r; end
      endcase
    end else if (dbusy_r) begin
      dn_nxt = {dn_r[WIDTH-2:0], 1'b0};
      if (!dtrial[WIDTH]) begin
        drem_nxt = dtrial[WIDTH-1:0];
        dq_nxt   = {dq_r[WIDTH-2:0], 1'b1};
      end else begin
        drem_nxt = {drem_r[WIDTH-2:0], dn_r[WIDTH-1]};
        dq_nxt   = {dq_r[WIDTH-2:0], 1'b0};
      end
      dc_nxt = dc_r - CW'(1);
      if (dc_r == CW'(1)) dbusy_nxt = 1'b0;
    end
  end

  // modular shift-and-add multiplier, operands below modulus
  assign mdbl   = {macc_r, 1'b0};
  assign mdbl_m = (mdbl >= {1'b0, mm_r}) ? WIDTH'(mdbl - {1'b0, mm_r}) : mdbl[WIDTH-1:0];
  assign madd   = {1'b0, mdbl_m} + {1'b0, ma_r};

  always_comb begin
    ma_nxt = ma_r; mb_nxt = mb_r; mm_nxt = mm_r; macc_nxt = macc_r;
    mc_nxt = mc_r; mbusy_nxt = mbusy_r;
    if (cmd.mul_start) begin
      mbusy_nxt = 1'b1;
      mc_nxt    = CW'(WIDTH);
      macc_nxt  = '0;
      mm_nxt    = n_r;
      if (cmd.mul_fin) begin
        ma_nxt = t0_r;
        mb_nxt = drem_r;
      end else begin
        ma_nxt = t1_r;
        mb_nxt = q_r;
      end
    end else if (mbusy_r) begin
      mb_nxt = {mb_r[WIDTH-2:0], 1'b0};
      if (mb_r[WIDTH-1]) begin
        macc_nxt = (madd >= {1'b0, mm_r}) ? WIDTH'(madd - {1'b0, mm_r}) : madd[WIDTH-1:0];
      end else begin
        macc_nxt = mdbl_m;
      end
      mc_nxt = mc_r - CW'(1);
      if (mc_r == CW'(1)) mbusy_nxt = 1'b0;
    end
  end

  assign prod_sub = (t0_r >= macc_r) ? (t0_r - macc_r) : (t0_r + (n_r - macc_r));

  always_comb begin
    k_nxt = k_r; s_nxt = s_r; n_nxt = n_r;
    ga_nxt = ga_r; gb_nxt = gb_r; ph2_nxt = ph2_r;
    r0_nxt = r0_r; r1_nxt = r1_r; t0_nxt = t0_r; t1_nxt = t1_r;
    q_nxt = q_r; sm_nxt = sm_r; sol_nxt = sol_r;
    if (cmd.load) begin
      k_nxt   = in_coeff;
      s_nxt   = in_target;
      n_nxt   = in_modulus;
      ga_nxt  = in_coeff;
      gb_nxt  = in_target;
      ph2_nxt = 1'b0;
      sol_nxt = '0;
    end
    if (cmd.gcd_next) begin
      gb_nxt  = n_r;
      ph2_nxt = 1'b1;
    end
    if (cmd.gcd_swap) begin
      ga_nxt = gb_r;
      gb_nxt = drem_r;
    end
    if (!dbusy_r && !cmd.div_start && !dbusy_nxt) begin
      sm_nxt = sm_r;
    end
    if (dbusy_r && dc_r == CW'(1)) begin
      // writeback follows completion in the next cycle, via registered op tracking
      sm_nxt = sm_r;
    end
    if (div_wb_rk) k_nxt = dq_r;
    if (div_wb_rs) s_nxt = dq_r;
    if (div_wb_rn) begin
      n_nxt  = dq_r;
      sol_nxt = '0;
    end
    if (div_wb_kmod) begin
      r0_nxt = n_r;
      r1_nxt = drem_r;
      t0_nxt = '0;
      t1_nxt = (n_r == WIDTH'(1)) ? '0 : WIDTH'(1);
    end
    if (div_wb_euq) begin
      // quotient never exceeds the modulus, so one subtract reduces it
      q_nxt  = (dq_r >= n_r) ? (dq_r - n_r) : dq_r;
      sm_nxt = drem_r;
    end
    if (cmd.eu_step) begin
      r0_nxt = r1_r;
      r1_nxt = sm_r;
      t0_nxt = t1_r;
      t1_nxt = prod_sub;
    end
    if (mul_wb_fin) sol_nxt = macc_r;
  end

  always_comb begin
    op_nxt  = cmd.div_start ? cmd.div_op : op_r;
    fin_nxt = cmd.mul_start ? cmd.mul_fin : fin_r;
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    fin_r  <= fin_nxt;
    dfin_r <= dbusy_r && (dc_r == CW'(1));
    mfin_r <= mbusy_r && (mc_r == CW'(1));
  end

  assign div_wb_rk   = dfin_r && op_r == DIV_RK;
  assign div_wb_rs   = dfin_r && op_r == DIV_RS;
  assign div_wb_rn   = dfin_r && op_r == DIV_RN;
  assign div_wb_kmod = dfin_r && op_r == DIV_KMOD;
  assign div_wb_euq  = dfin_r && op_r == DIV_EUQ;
  assign mul_wb_fin  = mfin_r && fin_r;

  always_comb begin
    sts.div_done   = dfin_r;
    sts.mul_done   = mfin_r;
    sts.n_zero     = (n_r == '0);
    sts.gcd_b_zero = (gb_r == '0);
    sts.gcd_phase2 = ph2_r;
    sts.r1_zero    = (r1_r == '0);
    sts.r0_one     = (r0_r == WIDTH'(1));
  end

  assign sol  = sol_r;
  assign nred = n_r;

endmodule
